// ===== rtl/linear_probe_hash_set_core_assert.svh =====
// ----------------------------------------------------------------------------
// linear probe hash set assertion macros
// wrappers for concurrent checks on clk
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_SET_CORE_ASSERT_SVH
`define LINEAR_PROBE_HASH_SET_CORE_ASSERT_SVH

// same-cycle implication
`define LPHS_ASSERT_NOW(name, rst_sig, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst_sig) (pre) |-> (post)) \
    else $error("lphs check failed");

// next-cycle implication
`define LPHS_ASSERT_NEXT(name, rst_sig, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst_sig) (pre) |=> (post)) \
    else $error("lphs check failed");

`endif

// ===== rtl/lphs_pkg.sv =====
// ----------------------------------------------------------------------------
// lphs_pkg
// shared constants, codes and types of the linear probe hash set
// ----------------------------------------------------------------------------
package lphs_pkg;

  localparam int FIELD_W             = 12;
  localparam int KEY_W               = 32;
  localparam int HASH_BITS_W         = 4;
  localparam int LOAD_LIMIT_W        = 12;
  localparam int CFG_DATA_W          = 12;
  localparam int CFG_INDEX_W         = 1;
  localparam int MIN_HASH_BITS       = 8;
  localparam int DEF_MAX_HASH_BITS   = 12;
  localparam int DEF_KEY_STORE_DEPTH = 3481;

  localparam logic [KEY_W-1:0]        HASH_MULT        = 32'd3141592653;
  localparam logic [HASH_BITS_W-1:0]  HASH_BITS_RESET  = 4'd8;
  localparam logic [LOAD_LIMIT_W-1:0] LOAD_LIMIT_RESET = 12'd217;

  localparam logic [CFG_INDEX_W-1:0] CFG_HASH_BITS  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOAD_LIMIT = 1'b1;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_LOOKUP  = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_READ,
    S_SLOT,
    S_KEY,
    S_FIN
  } seq_state_t;

  typedef struct packed {
    logic slot_rd;
    logic slot_wr;
    logic key_rd;
    logic key_wr;
  } tbl_cmd_t;

endpackage

// ===== rtl/lphs_cfg.sv =====
// ----------------------------------------------------------------------------
// lphs_cfg
// configuration registers with clamped effective table size
// ----------------------------------------------------------------------------
module lphs_cfg #(
  parameter int MAX_HASH_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lphs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lphs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic [$clog2(MAX_HASH_BITS+1)-1:0] eff_bits,
  output logic [lphs_pkg::LOAD_LIMIT_W-1:0] load_limit
);
  import lphs_pkg::*;

  localparam int HB_W  = $clog2(MAX_HASH_BITS + 1);
  localparam int CMP_W = (HB_W > HASH_BITS_W) ? HB_W : HASH_BITS_W;

  logic [HASH_BITS_W-1:0] hash_bits;
  logic [CMP_W-1:0]       hb_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_bits  <= HASH_BITS_RESET;
      load_limit <= LOAD_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HASH_BITS:  hash_bits  <= cfg_data[HASH_BITS_W-1:0];
        CFG_LOAD_LIMIT: load_limit <= cfg_data[LOAD_LIMIT_W-1:0];
        default:        hash_bits  <= hash_bits;
      endcase
    end
  end

  assign hb_ext = CMP_W'(hash_bits);

  always_comb begin
    priority if (hb_ext < CMP_W'(MIN_HASH_BITS)) begin
      eff_bits = HB_W'(MIN_HASH_BITS);
    end else if (hb_ext > CMP_W'(MAX_HASH_BITS)) begin
      eff_bits = HB_W'(MAX_HASH_BITS);
    end else begin
      eff_bits = HB_W'(hb_ext);
    end
  end

endmodule

// ===== rtl/lphs_hash.sv =====
// ----------------------------------------------------------------------------
// lphs_hash
// multiplicative hash: registered product, top bits select home slot
// ----------------------------------------------------------------------------
module lphs_hash #(
  parameter int MAX_HASH_BITS = 12
) (
  input  logic                                clk,
  input  logic                                start,
  input  logic signed [lphs_pkg::KEY_W-1:0]   key,
  input  logic [$clog2(MAX_HASH_BITS+1)-1:0]  eff_bits,
  output logic [MAX_HASH_BITS-1:0]            home
);
  import lphs_pkg::*;

  logic [KEY_W-1:0] prod_q;
  logic [5:0]       shamt;

  always_ff @(posedge clk) begin
    if (start) begin
      prod_q <= KEY_W'($unsigned(key) * HASH_MULT);
    end
  end

  assign shamt = 6'd32 - 6'(eff_bits);
  assign home  = MAX_HASH_BITS'(prod_q >> shamt);

endmodule

// ===== rtl/lphs_tables.sv =====
// ----------------------------------------------------------------------------
// lphs_tables
// slot table with clearing pass after reset, and key store
// ----------------------------------------------------------------------------
module lphs_tables #(
  parameter int MAX_HASH_BITS   = 12,
  parameter int KEY_STORE_DEPTH = 3481
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  lphs_pkg::tbl_cmd_t                       tbl_cmd,
  input  logic [MAX_HASH_BITS-1:0]                 slot_addr,
  input  logic [$clog2(KEY_STORE_DEPTH+1)-1:0]     slot_wdata,
  output logic [$clog2(KEY_STORE_DEPTH+1)-1:0]     slot_rdata,
  input  logic [$clog2(KEY_STORE_DEPTH)-1:0]       key_addr,
  input  logic [lphs_pkg::KEY_W-1:0]               key_wdata,
  output logic [lphs_pkg::KEY_W-1:0]               key_rdata,
  output logic                                     clearing
);
  import lphs_pkg::*;

  localparam int SLOTS = 1 << MAX_HASH_BITS;
  localparam int NUM_W = $clog2(KEY_STORE_DEPTH + 1);

  logic [NUM_W-1:0]         slot_mem [SLOTS];
  logic [KEY_W-1:0]         key_mem  [KEY_STORE_DEPTH];
  logic [MAX_HASH_BITS-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (&clr_addr) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      slot_mem[clr_addr] <= '0;
    end else if (tbl_cmd.slot_wr) begin
      slot_mem[slot_addr] <= slot_wdata;
    end
    if (tbl_cmd.slot_rd) begin
      slot_rdata <= slot_mem[slot_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_cmd.key_wr) begin
      key_mem[key_addr] <= key_wdata;
    end
    if (tbl_cmd.key_rd) begin
      key_rdata <= key_mem[key_addr];
    end
  end

endmodule

// ===== rtl/lphs_seq.sv =====
// ----------------------------------------------------------------------------
// lphs_seq
// probe sequencer: walks slots, compares keys, inserts, holds result
// ----------------------------------------------------------------------------
`include "linear_probe_hash_set_core_assert.svh"

module lphs_seq #(
  parameter int MAX_HASH_BITS   = 12,
  parameter int KEY_STORE_DEPTH = 3481
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [$clog2(MAX_HASH_BITS+1)-1:0]    eff_bits,
  input  logic [lphs_pkg::LOAD_LIMIT_W-1:0]     load_limit,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  cmd,
  input  logic signed [lphs_pkg::KEY_W-1:0]     key,
  input  logic [MAX_HASH_BITS-1:0]              home,
  output lphs_pkg::tbl_cmd_t                    tbl_cmd,
  output logic [MAX_HASH_BITS-1:0]              slot_addr,
  output logic [$clog2(KEY_STORE_DEPTH+1)-1:0]  slot_wdata,
  input  logic [$clog2(KEY_STORE_DEPTH+1)-1:0]  slot_rdata,
  output logic [$clog2(KEY_STORE_DEPTH)-1:0]    key_addr,
  output logic [lphs_pkg::KEY_W-1:0]            key_wdata,
  input  logic [lphs_pkg::KEY_W-1:0]            key_rdata,
  input  logic                                  clearing,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [lphs_pkg::FIELD_W-1:0]          slot,
  output logic [lphs_pkg::FIELD_W-1:0]          element_number,
  output logic                                  inserted_new,
  output logic                                  status,
  output logic [lphs_pkg::FIELD_W-1:0]          key_count
);
  import lphs_pkg::*;

  localparam int AW     = MAX_HASH_BITS;
  localparam int NUM_W  = $clog2(KEY_STORE_DEPTH + 1);
  localparam int KEY_AW = $clog2(KEY_STORE_DEPTH);
  localparam int LOAD_W = (NUM_W > LOAD_LIMIT_W) ? NUM_W : LOAD_LIMIT_W;

  seq_state_t       state, state_next;
  logic             cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [AW-1:0]    addr, home_q, addr_inc;
  logic [AW:0]      probes, size;
  logic [NUM_W-1:0] ent_q, stored_count, count_inc;
  logic             found_q, empty_q;
  logic             in_take, out_take, exhausted, ent_ok, key_match;
  logic             count_ok, new_ok, refuse;

  assign in_take   = in_valid && in_ready;
  assign out_take  = !out_valid || out_ready;
  assign size      = (AW + 1)'(1) << eff_bits;
  assign addr_inc  = (addr + 1'b1) & AW'(size - 1'b1);
  assign exhausted = (probes + 1'b1) == size;
  assign ent_ok    = slot_rdata <= NUM_W'(KEY_STORE_DEPTH);
  assign key_match = key_rdata == key_q;
  assign count_inc = stored_count + 1'b1;
  assign count_ok  = (LOAD_W'(stored_count) < LOAD_W'(load_limit)) &&
                     (stored_count < NUM_W'(KEY_STORE_DEPTH));
  assign new_ok    = (cmd_q == CMD_INSERT) && !found_q && empty_q && count_ok;
  assign refuse    = (cmd_q == CMD_INSERT) && !found_q && !new_ok;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_take) state_next = S_HASH;
      S_HASH: state_next = S_READ;
      S_READ: state_next = S_SLOT;
      S_SLOT: begin
        priority if (slot_rdata == '0) state_next = S_FIN;
        else if (ent_ok)               state_next = S_KEY;
        else if (exhausted)            state_next = S_FIN;
        else                           state_next = S_READ;
      end
      S_KEY: begin
        if (key_match || exhausted) state_next = S_FIN;
        else                        state_next = S_READ;
      end
      S_FIN: if (out_take) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory controls and handshake
  always_comb begin
    tbl_cmd    = '0;
    slot_addr  = addr;
    slot_wdata = count_inc;
    key_addr   = KEY_AW'(stored_count);
    key_wdata  = key_q;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: in_ready = !clearing;
      S_READ: tbl_cmd.slot_rd = 1'b1;
      S_SLOT: begin
        if (slot_rdata != '0 && ent_ok) begin
          tbl_cmd.key_rd = 1'b1;
          key_addr       = KEY_AW'(slot_rdata - 1'b1);
        end
      end
      S_FIN: begin
        if (out_take && new_ok) begin
          tbl_cmd.slot_wr = 1'b1;
          tbl_cmd.key_wr  = 1'b1;
        end
      end
      default: in_ready = 1'b0;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      stored_count <= '0;
    end else begin
      state <= state_next;
      if (state == S_FIN && out_take) begin
        out_valid <= 1'b1;
        if (new_ok) begin
          stored_count <= count_inc;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // probe datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          cmd_q <= cmd;
          key_q <= $unsigned(key);
        end
      end
      S_HASH: begin
        addr    <= home;
        home_q  <= home;
        probes  <= '0;
        found_q <= 1'b0;
        empty_q <= 1'b0;
      end
      S_SLOT: begin
        ent_q <= slot_rdata;
        if (slot_rdata == '0) begin
          empty_q <= 1'b1;
        end else if (!ent_ok) begin
          if (exhausted) begin
            addr <= home_q;
          end else begin
            addr   <= addr_inc;
            probes <= probes + 1'b1;
          end
        end
      end
      S_KEY: begin
        if (key_match) begin
          found_q <= 1'b1;
        end else if (exhausted) begin
          addr <= home_q;
        end else begin
          addr   <= addr_inc;
          probes <= probes + 1'b1;
        end
      end
      S_FIN: begin
        if (out_take) begin
          slot         <= FIELD_W'(addr);
          inserted_new <= new_ok;
          status       <= refuse ? STATUS_FULL : STATUS_OK;
          key_count    <= FIELD_W'(new_ok ? count_inc : stored_count);
          priority if (found_q) element_number <= FIELD_W'(ent_q);
          else if (new_ok)      element_number <= FIELD_W'(count_inc);
          else                  element_number <= '0;
        end
      end
      default: cmd_q <= cmd_q;
    endcase
  end

  `LPHS_ASSERT_NOW(a_ready_only_idle, rst, in_ready, state == S_IDLE && !clearing)
  `LPHS_ASSERT_NOW(a_no_slot_write_zero, rst, tbl_cmd.slot_wr, slot_wdata != '0)
  `LPHS_ASSERT_NOW(a_probe_in_range, rst, state == S_READ, probes < size)
  `LPHS_ASSERT_NEXT(a_count_step, rst, tbl_cmd.key_wr,
                    stored_count == $past(stored_count) + 1'b1)

endmodule

// ===== rtl/linear_probe_hash_set_core.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_set_core
// set of 32-bit keys in an open-addressed table with linear probing
//
//   channel  dir  handshake            payload
//   cfg      in   cfg_we               cfg_index, cfg_data
//   in       in   in_valid/in_ready    cmd, key
//   out      out  out_valid/out_ready  slot, element_number, inserted_new,
//                                      status, key_count
//
// accept to result: probing stops at an empty slot, at the slot that holds
// the key, or when every slot has been probed; each probe reads the slot
// memory, then the key memory when the slot holds a valid entry
// after reset a clearing pass writes every slot and empties the slot
// table; in_ready stays low meanwhile, config writes are still taken
// in_ready is high only between transactions, at the earliest as a result
// appears; a result not yet taken holds the next one in its final state
// ----------------------------------------------------------------------------
module linear_probe_hash_set_core #(
  parameter int MAX_HASH_BITS   = lphs_pkg::DEF_MAX_HASH_BITS,
  parameter int KEY_STORE_DEPTH = lphs_pkg::DEF_KEY_STORE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lphs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lphs_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               cmd,
  input  logic signed [lphs_pkg::KEY_W-1:0]  key,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [lphs_pkg::FIELD_W-1:0]       slot,
  output logic [lphs_pkg::FIELD_W-1:0]       element_number,
  output logic                               inserted_new,
  output logic                               status,
  output logic [lphs_pkg::FIELD_W-1:0]       key_count
);
  import lphs_pkg::*;

  localparam int HB_W   = $clog2(MAX_HASH_BITS + 1);
  localparam int NUM_W  = $clog2(KEY_STORE_DEPTH + 1);
  localparam int KEY_AW = $clog2(KEY_STORE_DEPTH);

  logic [HB_W-1:0]          eff_bits;
  logic [LOAD_LIMIT_W-1:0]  load_limit;
  logic [MAX_HASH_BITS-1:0] home, slot_addr;
  logic [NUM_W-1:0]         slot_wdata, slot_rdata;
  logic [KEY_AW-1:0]        key_addr;
  logic [KEY_W-1:0]         key_wdata, key_rdata;
  logic                     clearing;
  tbl_cmd_t                 tbl_cmd;

  lphs_cfg #(
    .MAX_HASH_BITS (MAX_HASH_BITS)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .eff_bits   (eff_bits),
    .load_limit (load_limit)
  );

  lphs_hash #(
    .MAX_HASH_BITS (MAX_HASH_BITS)
  ) u_hash (
    .clk      (clk),
    .start    (in_valid && in_ready),
    .key      (key),
    .eff_bits (eff_bits),
    .home     (home)
  );

  lphs_tables #(
    .MAX_HASH_BITS   (MAX_HASH_BITS),
    .KEY_STORE_DEPTH (KEY_STORE_DEPTH)
  ) u_tables (
    .clk        (clk),
    .rst        (rst),
    .tbl_cmd    (tbl_cmd),
    .slot_addr  (slot_addr),
    .slot_wdata (slot_wdata),
    .slot_rdata (slot_rdata),
    .key_addr   (key_addr),
    .key_wdata  (key_wdata),
    .key_rdata  (key_rdata),
    .clearing   (clearing)
  );

  lphs_seq #(
    .MAX_HASH_BITS   (MAX_HASH_BITS),
    .KEY_STORE_DEPTH (KEY_STORE_DEPTH)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .eff_bits       (eff_bits),
    .load_limit     (load_limit),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .key            (key),
    .home           (home),
    .tbl_cmd        (tbl_cmd),
    .slot_addr      (slot_addr),
    .slot_wdata     (slot_wdata),
    .slot_rdata     (slot_rdata),
    .key_addr       (key_addr),
    .key_wdata      (key_wdata),
    .key_rdata      (key_rdata),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .slot           (slot),
    .element_number (element_number),
    .inserted_new   (inserted_new),
    .status         (status),
    .key_count      (key_count)
  );

endmodule
